>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are clocked on clk and
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/rfns_pkg.sv
package rfns_pkg;

    // ring / table geometry
    localparam int RING_BITS    = 14;
    localparam int FINGER_COUNT = 14;
    localparam int Q_FRAC_BITS  = 16;

    // port field widths
    localparam int KEY_W     = 14;
    localparam int LAT_W     = 8;
    localparam int Q_W       = 32;
    localparam int SLOT_W    = 4;
    localparam int FUNC_W    = 2;
    localparam int RATE_W    = 17;
    localparam int RATE_FRAC = 16;
    localparam int CFG_IDX_W = 2;

    // slot counter wide enough for both the port and the table
    localparam int CNT_BITS = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
    localparam int CNT_W    = (CNT_BITS > SLOT_W) ? CNT_BITS : SLOT_W;
    localparam logic [CNT_W-1:0] LAST_K = CNT_W'(FINGER_COUNT - 1);

    // Q update datapath widths
    localparam int DIFF_W   = Q_W + 3;
    localparam int P1_W     = Q_W + RATE_W + 1;
    localparam int P2_W     = DIFF_W + RATE_W + 1;
    localparam int NQ_W     = P2_W - RATE_FRAC + 1;
    localparam int RND_HALF = 2 ** (RATE_FRAC - 1);

    localparam logic [RATE_W-1:0] RATE_ONE   = RATE_W'(2 ** RATE_FRAC);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(58982);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE   = 2'd0,
        FN_GREEDY  = 2'd1,
        FN_LEARNED = 2'd2,
        FN_UPDATE  = 2'd3
    } func_t;

    // one finger table slot
    typedef struct packed {
        logic [RING_BITS-1:0] key;
        logic [LAT_W-1:0]     lat;
        logic [Q_W-1:0]       q;
    } entry_t;

    // operands handed to the Q update unit
    typedef struct packed {
        logic [Q_W-1:0] qop;
        entry_t         ent;
    } qc_req_t;

endpackage

>>> rtl/ring_finger_next_hop_select.sv
// Next-hop selector for a Chord-style ring. The finger table sits in a ring of
// FINGER_COUNT cells that rotates one slot per clock past a head cell, where
// writes, Q updates and both lookups (greedy: least clockwise distance, first
// wins ties; learned: largest Q over the leading feasible fingers, last wins
// ties) are applied, so a full pass leaves the table in its original order.
// Each accepted item returns one result transfer. An item is taken in while
// idle; the scan then brings each of the FINGER_COUNT slots to the head, and a
// finish state loads the output register once it is free. A Q update holds the
// ring at its slot while the 4-stage multiply pipeline runs. No new item is
// taken until the finish state is left. A finished result waits in the output
// register while the next item is taken in. best_q is the largest Q after the
// item's own change. cfg_ready is always high; write registers only while idle.
`include "assert_macros.svh"

module ring_finger_next_hop_select (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // item channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rfns_pkg::FUNC_W-1:0]           func,
    input  logic [rfns_pkg::SLOT_W-1:0]           slot,
    input  logic [rfns_pkg::KEY_W-1:0]            entry_key,
    input  logic [rfns_pkg::LAT_W-1:0]            entry_latency,
    input  logic signed [rfns_pkg::Q_W-1:0]       q_operand,
    input  logic [rfns_pkg::KEY_W-1:0]            target_key,

    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rfns_pkg::SLOT_W-1:0]           next_slot,
    output logic                                  deliver_local,
    output logic signed [rfns_pkg::Q_W-1:0]       best_q,

    // register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rfns_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rfns_pkg::RATE_W-1:0]           cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [rfns_pkg::RING_BITS-1:0] own_key_reg;
    logic [rfns_pkg::RING_BITS-1:0] own_key_next;
    logic [rfns_pkg::RATE_W-1:0]    learn_rate_reg;
    logic [rfns_pkg::RATE_W-1:0]    learn_rate_next;
    logic [rfns_pkg::RATE_W-1:0]    discount_reg;
    logic [rfns_pkg::RATE_W-1:0]    discount_next;

    // item held for the whole pass
    rfns_pkg::func_t                func_reg;
    rfns_pkg::func_t                func_next;
    logic [rfns_pkg::SLOT_W-1:0]    slot_reg;
    logic [rfns_pkg::SLOT_W-1:0]    slot_next;
    logic [rfns_pkg::RING_BITS-1:0] ekey_reg;
    logic [rfns_pkg::RING_BITS-1:0] ekey_next;
    logic [rfns_pkg::LAT_W-1:0]     elat_reg;
    logic [rfns_pkg::LAT_W-1:0]     elat_next;
    logic [rfns_pkg::Q_W-1:0]       qop_reg;
    logic [rfns_pkg::Q_W-1:0]       qop_next;
    logic [rfns_pkg::RING_BITS-1:0] target_reg;
    logic [rfns_pkg::RING_BITS-1:0] target_next;

    // scan state
    logic [rfns_pkg::CNT_W-1:0]     k_reg;
    logic [rfns_pkg::CNT_W-1:0]     k_next;
    logic                           upd_done_reg;
    logic                           upd_done_next;
    logic [rfns_pkg::RING_BITS-1:0] best_d_reg;
    logic [rfns_pkg::RING_BITS-1:0] best_d_next;
    logic [rfns_pkg::CNT_W-1:0]     hop_reg;
    logic [rfns_pkg::CNT_W-1:0]     hop_next;
    logic signed [rfns_pkg::Q_W-1:0] bq_reg;
    logic signed [rfns_pkg::Q_W-1:0] bq_next;
    logic                           open_reg;
    logic                           open_next;
    logic                           local_reg;
    logic                           local_next;
    logic signed [rfns_pkg::Q_W-1:0] maxq_reg;
    logic signed [rfns_pkg::Q_W-1:0] maxq_next;

    // result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [rfns_pkg::SLOT_W-1:0]    next_slot_reg;
    logic [rfns_pkg::SLOT_W-1:0]    next_slot_next;
    logic                           deliver_local_reg;
    logic                           deliver_local_next;
    logic signed [rfns_pkg::Q_W-1:0] best_q_reg;
    logic signed [rfns_pkg::Q_W-1:0] best_q_next;

    // ring
    rfns_pkg::entry_t               ent [rfns_pkg::FINGER_COUNT];
    rfns_pkg::entry_t               head;
    rfns_pkg::entry_t               head_new;
    logic                           shift;

    // Q update unit
    rfns_pkg::qc_req_t              qc_req;
    logic                           qc_start;
    logic                           qc_done;
    logic signed [rfns_pkg::Q_W-1:0] qc_nq;

    logic                           in_xfer;
    logic                           out_free;
    logic                           match;
    logic                           calc_need;
    logic                           is_lookup;
    logic [rfns_pkg::RING_BITS-1:0] head_d;
    logic [rfns_pkg::RING_BITS-1:0] own_d;

    // ------------------------------------------------------------------
    // Finger ring: cell i reloads from cell i+1; the last cell takes the
    // (possibly rewritten) head slot, closing the loop.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < rfns_pkg::FINGER_COUNT; gi++)
    begin : g_cell
        rfns_pkg::entry_t cell_in;
        if (gi == rfns_pkg::FINGER_COUNT - 1)
        begin : g_tail
            assign cell_in = head_new;
        end
        else
        begin : g_body
            assign cell_in = ent[gi + 1];
        end

        rfns_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (cell_in),
            .dout  (ent[gi])
        );
    end

    assign head = ent[0];

    assign qc_req.qop = qop_reg;
    assign qc_req.ent = head;

    rfns_qcalc u_qcalc (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (qc_start),
        .req        (qc_req),
        .learn_rate (learn_rate_reg),
        .discount   (discount_reg),
        .done       (qc_done),
        .nq         (qc_nq)
    );

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // head cell view; k_reg is the slot currently at the head
    assign match     = (rfns_pkg::CNT_W'(slot_reg) == k_reg);
    assign calc_need = (func_reg == rfns_pkg::FN_UPDATE) && match && !upd_done_reg;
    assign is_lookup = (func_reg == rfns_pkg::FN_GREEDY) || (func_reg == rfns_pkg::FN_LEARNED);
    assign head_d    = target_reg - head.key;
    assign own_d     = target_reg - own_key_reg;

    always_comb
    begin
        head_new = head;
        if (match && (func_reg == rfns_pkg::FN_WRITE))
        begin
            head_new.key = ekey_reg;
            head_new.lat = elat_reg;
            head_new.q   = qop_reg;
        end
        else if (match && (func_reg == rfns_pkg::FN_UPDATE))
        begin
            head_new.q = qc_nq;
        end
    end

    // configuration writes
    always_comb
    begin
        own_key_next    = own_key_reg;
        learn_rate_next = learn_rate_reg;
        discount_next   = discount_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rfns_pkg::REG_OWN_KEY:
                begin
                    own_key_next = rfns_pkg::RING_BITS'(cfg_data[rfns_pkg::KEY_W-1:0]);
                end
                rfns_pkg::REG_LEARN_RATE:
                begin
                    learn_rate_next = cfg_data;
                end
                rfns_pkg::REG_DISCOUNT:
                begin
                    discount_next = cfg_data;
                end
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // sequencer and scan
    always_comb
    begin
        state_next         = state_reg;
        func_next          = func_reg;
        slot_next          = slot_reg;
        ekey_next          = ekey_reg;
        elat_next          = elat_reg;
        qop_next           = qop_reg;
        target_next        = target_reg;
        k_next             = k_reg;
        upd_done_next      = upd_done_reg;
        best_d_next        = best_d_reg;
        hop_next           = hop_reg;
        bq_next            = bq_reg;
        open_next          = open_reg;
        local_next         = local_reg;
        maxq_next          = maxq_reg;
        next_slot_next     = next_slot_reg;
        deliver_local_next = deliver_local_reg;
        best_q_next        = best_q_reg;
        out_valid_next     = out_valid_reg;
        shift              = 1'b0;
        qc_start           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next     = rfns_pkg::func_t'(func);
                    slot_next     = slot;
                    ekey_next     = rfns_pkg::RING_BITS'(entry_key);
                    elat_next     = entry_latency;
                    qop_next      = q_operand;
                    target_next   = rfns_pkg::RING_BITS'(target_key);
                    k_next        = '0;
                    upd_done_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (calc_need)
                begin
                    // hold the ring while the update pipeline runs
                    qc_start   = 1'b1;
                    state_next = S_CALC;
                end
                else
                begin
                    shift  = 1'b1;
                    k_next = k_reg + 1'b1;
                    if (k_reg == '0)
                    begin
                        best_d_next = head_d;
                        hop_next    = '0;
                        bq_next     = head.q;
                        open_next   = 1'b1;
                        local_next  = (own_d < head_d);
                        maxq_next   = head_new.q;
                    end
                    else
                    begin
                        if (head_d < best_d_reg)
                        begin
                            best_d_next = head_d;
                            if (func_reg == rfns_pkg::FN_GREEDY)
                            begin
                                hop_next = k_reg;
                            end
                        end
                        // learned lookup stops at the first finger past own node
                        if ((func_reg == rfns_pkg::FN_LEARNED) && open_reg)
                        begin
                            if (own_d < head_d)
                            begin
                                open_next = 1'b0;
                            end
                            else if ($signed(head.q) >= bq_reg)
                            begin
                                bq_next  = head.q;
                                hop_next = k_reg;
                            end
                        end
                        if ($signed(head_new.q) > maxq_reg)
                        begin
                            maxq_next = head_new.q;
                        end
                    end
                    if (k_reg == rfns_pkg::LAST_K)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CALC:
            begin
                if (qc_done)
                begin
                    upd_done_next = 1'b1;
                    state_next    = S_SCAN;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    next_slot_next     = (is_lookup && !local_reg)
                                         ? rfns_pkg::SLOT_W'(hop_reg) : '0;
                    deliver_local_next = is_lookup && local_reg;
                    best_q_next        = maxq_reg;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            own_key_reg    <= '0;
            learn_rate_reg <= rfns_pkg::RATE_RESET;
            discount_reg   <= rfns_pkg::RATE_RESET;
            k_reg          <= '0;
            upd_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            own_key_reg    <= own_key_next;
            learn_rate_reg <= learn_rate_next;
            discount_reg   <= discount_next;
            k_reg          <= k_next;
            upd_done_reg   <= upd_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg          <= func_next;
        slot_reg          <= slot_next;
        ekey_reg          <= ekey_next;
        elat_reg          <= elat_next;
        qop_reg           <= qop_next;
        target_reg        <= target_next;
        best_d_reg        <= best_d_next;
        hop_reg           <= hop_next;
        bq_reg            <= bq_next;
        open_reg          <= open_next;
        local_reg         <= local_next;
        maxq_reg          <= maxq_next;
        next_slot_reg     <= next_slot_next;
        deliver_local_reg <= deliver_local_next;
        best_q_reg        <= best_q_next;
    end

    assign out_valid     = out_valid_reg;
    assign next_slot     = next_slot_reg;
    assign deliver_local = deliver_local_reg;
    assign best_q        = best_q_reg;

    // checks
    `ASSERT_CLK(a_result_after_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "stray result")
    `ASSERT_IMPLY(a_scan_in_range, state_reg == S_SCAN, k_reg <= rfns_pkg::LAST_K, "scan slot range")
    `ASSERT_IMPLY(a_update_in_calc, qc_done, state_reg == S_CALC, "Q update done outside wait")
    `ASSERT_IMPLY(a_local_no_hop, out_valid_reg && deliver_local_reg, next_slot_reg == '0, "local hop")

endmodule

>>> rtl/rfns_cell.sv
module rfns_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  rfns_pkg::entry_t din,
    output rfns_pkg::entry_t dout
);

    rfns_pkg::entry_t ent_reg;
    rfns_pkg::entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (shift)
        begin
            ent_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign dout = ent_reg;

endmodule

>>> rtl/rfns_qcalc.sv
module rfns_qcalc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  rfns_pkg::qc_req_t                   req,
    input  logic [rfns_pkg::RATE_W-1:0]         learn_rate,
    input  logic [rfns_pkg::RATE_W-1:0]         discount,
    output logic                                done,
    output logic signed [rfns_pkg::Q_W-1:0]     nq
);

    // rates above one saturate to one
    logic [rfns_pkg::RATE_W-1:0] lr_c;
    logic [rfns_pkg::RATE_W-1:0] disc_c;

    logic [3:0] v_reg;
    logic [3:0] v_next;

    // stage 1: discount * propagated Q
    logic signed [rfns_pkg::P1_W-1:0]  p1_reg;
    logic signed [rfns_pkg::P1_W-1:0]  p1_next;
    logic [rfns_pkg::Q_W-1:0]          q1_reg;
    logic [rfns_pkg::LAT_W-1:0]        lat1_reg;

    // stage 2: temporal difference
    logic signed [rfns_pkg::P1_W-1:0]   p1_rnd;
    logic signed [rfns_pkg::P1_W-1:0]   p1_sh;
    logic signed [rfns_pkg::DIFF_W-1:0] qd_ext;
    logic signed [rfns_pkg::DIFF_W-1:0] q_ext;
    logic signed [rfns_pkg::DIFF_W-1:0] lat_ext;
    logic signed [rfns_pkg::DIFF_W-1:0] diff_reg;
    logic signed [rfns_pkg::DIFF_W-1:0] diff_next;
    logic [rfns_pkg::Q_W-1:0]           q2_reg;

    // stage 3: learn_rate * difference
    logic signed [rfns_pkg::P2_W-1:0] p2_reg;
    logic signed [rfns_pkg::P2_W-1:0] p2_next;
    logic [rfns_pkg::Q_W-1:0]         q3_reg;

    // stage 4: accumulate and saturate
    logic signed [rfns_pkg::P2_W-1:0]       p2_rnd;
    logic signed [rfns_pkg::P2_W-1:0]       p2_sh;
    logic signed [rfns_pkg::NQ_W-1:0]       nq_sum;
    logic [rfns_pkg::NQ_W-rfns_pkg::Q_W:0]  nq_top;
    logic signed [rfns_pkg::Q_W-1:0]        nq_reg;
    logic signed [rfns_pkg::Q_W-1:0]        nq_next;

    assign lr_c   = (learn_rate > rfns_pkg::RATE_ONE) ? rfns_pkg::RATE_ONE : learn_rate;
    assign disc_c = (discount > rfns_pkg::RATE_ONE) ? rfns_pkg::RATE_ONE : discount;

    assign v_next  = {v_reg[2:0], start};
    assign p1_next = $signed(req.qop) * $signed({1'b0, disc_c});

    // round to nearest, ties up, then drop the rate fraction
    assign p1_rnd  = p1_reg + rfns_pkg::P1_W'(rfns_pkg::RND_HALF);
    assign p1_sh   = p1_rnd >>> rfns_pkg::RATE_FRAC;
    assign qd_ext  = p1_sh[rfns_pkg::DIFF_W-1:0];
    assign q_ext   = {{(rfns_pkg::DIFF_W - rfns_pkg::Q_W){q1_reg[rfns_pkg::Q_W-1]}}, q1_reg};
    assign lat_ext = {{(rfns_pkg::DIFF_W - rfns_pkg::LAT_W - rfns_pkg::Q_FRAC_BITS){1'b0}},
                      lat1_reg, {rfns_pkg::Q_FRAC_BITS{1'b0}}};
    assign diff_next = qd_ext - lat_ext - q_ext;

    assign p2_next = diff_reg * $signed({1'b0, lr_c});

    assign p2_rnd = p2_reg + rfns_pkg::P2_W'(rfns_pkg::RND_HALF);
    assign p2_sh  = p2_rnd >>> rfns_pkg::RATE_FRAC;
    assign nq_sum = {{(rfns_pkg::NQ_W - rfns_pkg::Q_W){q3_reg[rfns_pkg::Q_W-1]}}, q3_reg}
                    + p2_sh[rfns_pkg::NQ_W-1:0];
    assign nq_top = nq_sum[rfns_pkg::NQ_W-1:rfns_pkg::Q_W-1];

    always_comb
    begin
        if ((nq_top == '0) || (nq_top == '1))
        begin
            nq_next = nq_sum[rfns_pkg::Q_W-1:0];
        end
        else if (nq_sum[rfns_pkg::NQ_W-1])
        begin
            nq_next = {1'b1, {(rfns_pkg::Q_W-1){1'b0}}};
        end
        else
        begin
            nq_next = {1'b0, {(rfns_pkg::Q_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        q1_reg   <= req.ent.q;
        lat1_reg <= req.ent.lat;
        diff_reg <= diff_next;
        q2_reg   <= q1_reg;
        p2_reg   <= p2_next;
        q3_reg   <= q2_reg;
        nq_reg   <= nq_next;
    end

    assign done = v_reg[3];
    assign nq   = nq_reg;

endmodule
